### rtl/gtcg_pkg.sv
// ============================================================================
// gtcg_pkg: shared types and constants of the LCD text command generator
// Holds the display write record and the fixed command codes and step
// numbers of the write sequence for one character.
// ============================================================================
package gtcg_pkg;

    typedef struct packed {
        logic       side;
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } write_t;

    localparam logic [7:0] CMD_PAGE = 8'hB8;
    localparam logic [7:0] CMD_COL0 = 8'h40;

    localparam logic [4:0] LINE_SLOTS = 5'd16;
    localparam logic [4:0] HALF_SLOTS = 5'd8;

    localparam logic [6:0] CODE_LAST_PAGE  = 7'd8;
    localparam logic [6:0] CODE_FIRST_CHAR = 7'd32;

    localparam logic [3:0] STEP_PAGE_R     = 4'd0;
    localparam logic [3:0] STEP_COL_R      = 4'd1;
    localparam logic [3:0] STEP_PAGE_L     = 4'd2;
    localparam logic [3:0] STEP_COL_L      = 4'd3;
    localparam logic [3:0] STEP_COLUMN0    = 4'd4;
    localparam logic [3:0] STEP_COLUMN1    = 4'd5;
    localparam logic [3:0] STEP_COLUMN2    = 4'd6;
    localparam logic [3:0] STEP_COLUMN3    = 4'd7;
    localparam logic [3:0] STEP_COLUMN4    = 4'd8;
    localparam logic [3:0] STEP_BLANK      = 4'd9;
    localparam logic [3:0] STEP_LAST_DATA  = 4'd11;

endpackage

### rtl/glcd_text_command_generator.sv
// ============================================================================
// glcd_text_command_generator: text renderer for a two-half 128x64 LCD
// Turns character codes into the display writes for a 5x7 font.
// ============================================================================
// The char channel (char_valid, char_stall, char_code) takes one character
// code per item. The write channel (wr_valid, wr_stall, side, is_data,
// bus_byte, last) gives one display write per item; last marks the final
// write of a character. Codes 0 to 8 give four page commands, printable
// codes give eight data writes, or twelve when the line wraps, and codes
// 9 to 31 give no write at all.
// The first write of a character passes through the buffer, the sequencer
// state and the write register. Writes then leave one per cycle while
// wr_stall is low, and the next character is held in a one-entry buffer so
// that its writes follow the previous ones without a gap. The write
// sequencer emits one write per cycle unless wr_stall holds it.
// Reset places the cursor at slot 0 of page 0 and empties both registers.
// While wr_stall is high the write register holds its item, the sequencer
// waits, and char_stall rises once the buffer is full.
// ============================================================================
module glcd_text_command_generator
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [6:0] char_code,
    output logic       wr_valid,
    input  logic       wr_stall,
    output logic       side,
    output logic       is_data,
    output logic [7:0] bus_byte,
    output logic       last
);

    logic              buf_valid_reg, buf_valid_next;
    logic [6:0]        buf_code_reg;
    logic              out_valid_reg, out_valid_next;
    gtcg_pkg::write_t  out_reg;

    logic              out_ready;
    logic              take;
    logic              seq_active;
    gtcg_pkg::write_t  seq_wr;
    logic              char_accept;

    assign char_stall  = buf_valid_reg;
    assign char_accept = char_valid && !buf_valid_reg;
    assign out_ready   = !out_valid_reg || !wr_stall;

    gtcg_sequencer u_sequencer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .buf_valid (buf_valid_reg),
        .buf_code  (buf_code_reg),
        .advance   (out_ready),
        .take      (take),
        .wr_active (seq_active),
        .wr        (seq_wr)
    );

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (take)
        begin
            buf_valid_next = 1'b0;
        end
        else if (char_accept)
        begin
            buf_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = seq_active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            buf_code_reg <= char_code;
        end
        if (out_ready && seq_active)
        begin
            out_reg <= seq_wr;
        end
    end

    assign wr_valid = out_valid_reg;
    assign side     = out_reg.side;
    assign is_data  = out_reg.is_data;
    assign bus_byte = out_reg.bus_byte;
    assign last     = out_reg.last;

    // The buffer is only emptied by the sequencer when it holds an item.
    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> buf_valid_reg)
        else $error("sequencer took from an empty buffer");

    // A buffered item is never replaced before the sequencer takes it.
    a_buffer_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && !take) |=> (buf_valid_reg && $stable(buf_code_reg)))
        else $error("buffered item lost");

    // A write held under stall is not replaced by the sequencer.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wr_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled write changed");

endmodule

### rtl/gtcg_sequencer.sv
// ============================================================================
// gtcg_sequencer: per-character write sequencer
// Takes one character code from the input buffer, updates the line position
// and steps through the page commands and the font columns, one write per
// advance.
// ============================================================================
module gtcg_sequencer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 buf_valid,
    input  logic [6:0]           buf_code,
    input  logic                 advance,
    output logic                 take,
    output logic                 wr_active,
    output gtcg_pkg::write_t     wr
);

    localparam logic [39:0] GLYPH_ROM [96] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_30_30_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
        40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
        40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
        40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
        40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
        40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
        40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
        40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
        40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
        40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
        40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
        40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_08_2A_1C_08, 40'h08_1C_2A_08_08
    };

    logic       active_reg, active_next;
    logic [3:0] step_reg, step_next;
    logic       glyph_reg, glyph_next;
    logic       side_reg, side_next;
    logic [6:0] index_reg, index_next;
    logic [4:0] slot_reg, slot_next;
    logic [2:0] page_reg, page_next;

    logic       last_step;
    logic       is_page_code;
    logic       is_char_code;
    logic       line_full;
    logic [39:0] glyph_row;

    assign last_step    = glyph_reg ? (step_reg == gtcg_pkg::STEP_LAST_DATA)
                                    : (step_reg == gtcg_pkg::STEP_COL_L);
    assign take         = buf_valid && (!active_reg || (advance && last_step));
    assign is_page_code = (buf_code <= gtcg_pkg::CODE_LAST_PAGE);
    assign is_char_code = (buf_code >= gtcg_pkg::CODE_FIRST_CHAR);
    assign line_full    = (slot_reg >= gtcg_pkg::LINE_SLOTS);

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        glyph_next  = glyph_reg;
        side_next   = side_reg;
        index_next  = index_reg;
        slot_next   = slot_reg;
        page_next   = page_reg;
        if (take)
        begin
            if (is_page_code)
            begin
                active_next = 1'b1;
                glyph_next  = 1'b0;
                step_next   = gtcg_pkg::STEP_PAGE_R;
                page_next   = buf_code[2:0] + 3'd7;
                slot_next   = 5'd0;
            end
            else if (is_char_code)
            begin
                active_next = 1'b1;
                glyph_next  = 1'b1;
                index_next  = buf_code - gtcg_pkg::CODE_FIRST_CHAR;
                if (line_full)
                begin
                    step_next = gtcg_pkg::STEP_PAGE_R;
                    page_next = page_reg + 3'd1;
                    slot_next = 5'd1;
                    side_next = 1'b0;
                end
                else
                begin
                    step_next = gtcg_pkg::STEP_COLUMN0;
                    slot_next = slot_reg + 5'd1;
                    side_next = (slot_reg >= gtcg_pkg::HALF_SLOTS);
                end
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else if (active_reg && advance)
        begin
            if (last_step)
            begin
                active_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            slot_reg   <= 5'd0;
            page_reg   <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            slot_reg   <= slot_next;
            page_reg   <= page_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        glyph_reg <= glyph_next;
        side_reg  <= side_next;
        index_reg <= index_next;
    end

    assign glyph_row = GLYPH_ROM[index_reg];
    assign wr_active = active_reg;

    always_comb
    begin
        wr.side     = side_reg;
        wr.is_data  = 1'b1;
        wr.bus_byte = 8'h00;
        wr.last     = last_step;
        case (step_reg) inside
            gtcg_pkg::STEP_PAGE_R:
            begin
                wr.side     = 1'b1;
                wr.is_data  = 1'b0;
                wr.bus_byte = gtcg_pkg::CMD_PAGE | {5'd0, page_reg};
            end
            gtcg_pkg::STEP_COL_R:
            begin
                wr.side     = 1'b1;
                wr.is_data  = 1'b0;
                wr.bus_byte = gtcg_pkg::CMD_COL0;
            end
            gtcg_pkg::STEP_PAGE_L:
            begin
                wr.side     = 1'b0;
                wr.is_data  = 1'b0;
                wr.bus_byte = gtcg_pkg::CMD_PAGE | {5'd0, page_reg};
            end
            gtcg_pkg::STEP_COL_L:
            begin
                wr.side     = 1'b0;
                wr.is_data  = 1'b0;
                wr.bus_byte = gtcg_pkg::CMD_COL0;
            end
            gtcg_pkg::STEP_COLUMN0: wr.bus_byte = glyph_row[39:32];
            gtcg_pkg::STEP_COLUMN1: wr.bus_byte = glyph_row[31:24];
            gtcg_pkg::STEP_COLUMN2: wr.bus_byte = glyph_row[23:16];
            gtcg_pkg::STEP_COLUMN3: wr.bus_byte = glyph_row[15:8];
            gtcg_pkg::STEP_COLUMN4: wr.bus_byte = glyph_row[7:0];
            [gtcg_pkg::STEP_BLANK:gtcg_pkg::STEP_LAST_DATA]: wr.bus_byte = 8'h00;
            default: wr.bus_byte = 8'h00;
        endcase
    end

    // The step counter never runs past the last write of its item.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_reg <= gtcg_pkg::STEP_LAST_DATA))
        else $error("step counter out of range");

    // A page select item stops after the four positioning commands.
    a_page_only_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !glyph_reg) |-> (step_reg <= gtcg_pkg::STEP_COL_L))
        else $error("page select item ran into data writes");

    // The line position never passes a full line.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= gtcg_pkg::LINE_SLOTS)
        else $error("slot count out of range");

    // A wrapped line restarts at the first slot on the next page.
    a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_char_code && line_full) |=>
            (slot_reg == 5'd1) && (page_reg == $past(page_reg) + 3'd1))
        else $error("line wrap did not advance the page");

endmodule
